// ----- rtl/core/iee_pkg.sv -----
// Shared types and constants for the infix expression evaluator.
package iee_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int DATA_W = 32;

   localparam logic [2:0] TOK_DIGIT  = 3'd0;
   localparam logic [2:0] TOK_PLUS   = 3'd1;
   localparam logic [2:0] TOK_MINUS  = 3'd2;
   localparam logic [2:0] TOK_TIMES  = 3'd3;
   localparam logic [2:0] TOK_DIVIDE = 3'd4;
   localparam logic [2:0] TOK_OPEN   = 3'd5;
   localparam logic [2:0] TOK_CLOSE  = 3'd6;
   localparam logic [2:0] TOK_END    = 3'd7;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_DIVZERO   = 2'd1;
   localparam logic [1:0] ERR_MALFORMED = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

   // datapath commands
   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_PUSHV  = 3'd1,  // push digit onto value stack
      CMD_PUSHO  = 3'd2,  // push operator code
      CMD_POPO   = 3'd3,  // drop top operator
      CMD_LOADV  = 3'd4,  // read two top values into operand registers
      CMD_EXEC   = 3'd5,  // start the arithmetic on loaded operands
      CMD_CLEAR  = 3'd6   // return stacks to empty
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [2:0] opcode;
   } ctl_type;

   typedef struct packed {
      logic       ops_empty;
      logic       ops_full;
      logic       vals_full;
      logic       vals_lt2;
      logic       vals_one;
      logic [2:0] top_op;
      logic       busy;      // arithmetic running
      logic       divzero;   // loaded divisor is zero
   } stat_type;

   function automatic logic [1:0] rank_of(input logic [2:0] o);
      rank_of = (o == TOK_TIMES || o == TOK_DIVIDE) ? 2'd2 : 2'd1;
   endfunction

endpackage

// ----- rtl/core/iee_datapath.sv -----
// Stacks, operand registers and the iterative arithmetic unit.
module iee_datapath #(
   parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  iee_pkg::ctl_type        ctl,
   input  logic [3:0]              digit,
   output iee_pkg::stat_type       stat,
   output logic [iee_pkg::DATA_W-1:0] bottom_value
);
   import iee_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [2:0]        ops_mem [STACK_DEPTH];
   logic [DATA_W-1:0] vals_mem [STACK_DEPTH];
   logic [CW-1:0]     ocnt_ff, ocnt_in, vcnt_ff, vcnt_in;
   logic [DATA_W-1:0] lhs_ff, rhs_ff, bot_ff;
   logic [2:0]        top_ff;

   // arithmetic unit state
   logic [DATA_W-1:0] rem_ff, quo_ff, mc_ff, acc_ff;
   logic [5:0]        step_ff;
   logic              busy_ff, mul_ff, neg_ff, done_ff;

   logic [AW-1:0] vtop, vnext, otop;
   assign vtop  = AW'(vcnt_ff - CW'(1));
   assign vnext = AW'(vcnt_ff - CW'(2));
   assign otop  = AW'(ocnt_ff - CW'(1));

   always_comb begin
      ocnt_in = ocnt_ff;
      vcnt_in = vcnt_ff;
      case (ctl.cmd)
         CMD_PUSHV: vcnt_in = vcnt_ff + CW'(1);
         CMD_PUSHO: ocnt_in = ocnt_ff + CW'(1);
         CMD_POPO:  ocnt_in = ocnt_ff - CW'(1);
         CMD_LOADV: vcnt_in = vcnt_ff - CW'(2);
         CMD_CLEAR: begin
            ocnt_in = '0;
            vcnt_in = '0;
         end
         default: ;
      endcase
      if (done_ff) vcnt_in = vcnt_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff <= '0;
         vcnt_ff <= '0;
      end else begin
         ocnt_ff <= ocnt_in;
         vcnt_ff <= vcnt_in;
      end
   end

   // memories: one write, registered reads
   always_ff @(posedge clock) begin
      if (ctl.cmd == CMD_PUSHO) ops_mem[AW'(ocnt_ff)] <= ctl.opcode;
      if (ctl.cmd == CMD_PUSHV) vals_mem[AW'(vcnt_ff)] <= {28'd0, digit};
      else if (done_ff) vals_mem[AW'(vcnt_ff)] <= acc_ff;
      if (ctl.cmd == CMD_LOADV) begin
         rhs_ff <= vals_mem[vtop];
         lhs_ff <= vals_mem[vnext];
      end
      top_ff <= ops_mem[AW'(ocnt_in - CW'(1))];
      bot_ff <= vals_mem[AW'(0)];
   end

   // write-through for top of operator stack after push
   logic [2:0] top_now;
   logic       top_byp_ff;
   logic [2:0] top_byp_val_ff;
   always_ff @(posedge clock) begin
      top_byp_ff     <= (ctl.cmd == CMD_PUSHO);
      top_byp_val_ff <= ctl.opcode;
   end
   assign top_now = top_byp_ff ? top_byp_val_ff : top_ff;

   // shift-add multiply or restoring divide, one bit per cycle
   logic [DATA_W:0]   trial;
   logic [DATA_W-1:0] rem_sh;
   assign rem_sh = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
   assign trial  = {1'b0, rem_sh} - {1'b0, mc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.cmd == CMD_EXEC) begin
            case (ctl.opcode)
               TOK_PLUS: begin
                  acc_ff  <= lhs_ff + rhs_ff;
                  done_ff <= 1'b1;
               end
               TOK_MINUS: begin
                  acc_ff  <= lhs_ff - rhs_ff;
                  done_ff <= 1'b1;
               end
               TOK_TIMES: begin
                  busy_ff <= 1'b1;
                  mul_ff  <= 1'b1;
                  acc_ff  <= '0;
                  quo_ff  <= lhs_ff;
                  mc_ff   <= rhs_ff;
                  step_ff <= 6'd0;
               end
               default: begin
                  busy_ff <= 1'b1;
                  mul_ff  <= 1'b0;
                  neg_ff  <= lhs_ff[DATA_W-1] ^ rhs_ff[DATA_W-1];
                  quo_ff  <= lhs_ff[DATA_W-1] ? -lhs_ff : lhs_ff;
                  mc_ff   <= rhs_ff[DATA_W-1] ? -rhs_ff : rhs_ff;
                  rem_ff  <= '0;
                  step_ff <= 6'd0;
               end
            endcase
         end else if (busy_ff) begin
            if (mul_ff) begin
               // lsb-first: acc += mc<<step when bit set
               if (quo_ff[0]) acc_ff <= acc_ff + mc_ff;
               quo_ff <= quo_ff >> 1;
               mc_ff  <= mc_ff << 1;
            end else begin
               if (!trial[DATA_W]) begin
                  rem_ff <= trial[DATA_W-1:0];
                  quo_ff <= {quo_ff[DATA_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
               end
            end
            step_ff <= step_ff + 6'd1;
            if (step_ff == 6'(DATA_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               if (!mul_ff) begin
                  acc_ff <= neg_ff ? -{quo_ff[DATA_W-2:0], !trial[DATA_W]}
                                   :  {quo_ff[DATA_W-2:0], !trial[DATA_W]};
               end else if (quo_ff[0]) begin
                  acc_ff <= acc_ff + mc_ff;
               end
            end
         end
      end
   end

   assign stat.ops_empty = (ocnt_ff == '0);
   assign stat.ops_full  = (ocnt_ff >= CW'(STACK_DEPTH));
   assign stat.vals_full = (vcnt_ff >= CW'(STACK_DEPTH));
   assign stat.vals_lt2  = (vcnt_ff < CW'(2));
   assign stat.vals_one  = (vcnt_ff == CW'(1));
   assign stat.top_op    = top_now;
   assign stat.busy      = busy_ff | done_ff;
   assign stat.divzero   = (rhs_ff == '0);
   assign bottom_value   = bot_ff;
endmodule

// ----- rtl/core/iee_control.sv -----
// Token sequencer that issues stack and arithmetic commands.
module iee_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_op,
   input  logic [3:0]           req_digit_value,
   input  logic                 req_bad_char,
   input  iee_pkg::stat_type    stat,
   output iee_pkg::ctl_type     ctl,
   output logic [3:0]           digit,
   input  logic [iee_pkg::DATA_W-1:0] bottom_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [iee_pkg::DATA_W-1:0] rsp_result_value,
   output logic [1:0]           rsp_status
);
   import iee_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SETL  = 8'b0000_0010,  // wait for top-of-stack read
      S_LOOK  = 8'b0000_0100,  // decide on top operator
      S_LOAD  = 8'b0000_1000,
      S_EXEC  = 8'b0001_0000,
      S_WAIT  = 8'b0010_0000,
      S_FIN   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] tok_ff, tok_in, cur_ff, cur_in;
   logic [1:0] err_ff, err_in;
   logic       ov_ff, ov_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [1:0] sts_ff, sts_in;

   logic accept;
   assign req_stall = (state_ff != S_IDLE) || ov_ff;
   assign accept    = req_valid && !req_stall;
   // the digit is written in the cycle its request is taken
   assign digit     = req_digit_value;

   always_comb begin
      state_in = state_ff;
      tok_in   = tok_ff;
      cur_in   = cur_ff;
      err_in   = err_ff;
      ov_in    = ov_ff;
      res_in   = res_ff;
      sts_in   = sts_ff;
      ctl.cmd    = CMD_NONE;
      ctl.opcode = cur_ff;
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && !req_bad_char) begin
               tok_in = req_op;
               if (req_op == TOK_END) begin
                  state_in = S_SETL;
               end else if (err_ff == ERR_NONE) begin
                  case (req_op)
                     TOK_DIGIT: begin
                        if (stat.vals_full) err_in = ERR_OVERFLOW;
                        else begin
                           ctl.cmd = CMD_PUSHV;
                        end
                     end
                     TOK_OPEN: begin
                        if (stat.ops_full) err_in = ERR_OVERFLOW;
                        else begin
                           ctl.cmd    = CMD_PUSHO;
                           ctl.opcode = TOK_OPEN;
                           state_in   = S_SETL;
                        end
                     end
                     default: state_in = S_SETL;
                  endcase
               end
            end
         end
         S_SETL: state_in = S_LOOK;
         S_LOOK: begin
            cur_in = stat.top_op;
            if (tok_ff == TOK_OPEN) begin
               state_in = S_IDLE;
            end else if (tok_ff == TOK_END) begin
               if (err_ff != ERR_NONE || stat.ops_empty) state_in = S_FIN;
               else if (stat.top_op == TOK_OPEN) begin
                  err_in = ERR_MALFORMED;
                  state_in = S_FIN;
               end else begin
                  ctl.cmd = CMD_POPO;
                  state_in = S_LOAD;
               end
            end else if (tok_ff == TOK_CLOSE) begin
               if (stat.ops_empty) begin
                  err_in = ERR_MALFORMED;
                  state_in = S_IDLE;
               end else begin
                  ctl.cmd = CMD_POPO;
                  state_in = (stat.top_op == TOK_OPEN) ? S_IDLE : S_LOAD;
               end
            end else begin
               // binary operator: reduce while top ranks at least as high
               if (!stat.ops_empty && stat.top_op != TOK_OPEN &&
                   rank_of(stat.top_op) >= rank_of(tok_ff)) begin
                  ctl.cmd = CMD_POPO;
                  state_in = S_LOAD;
               end else if (stat.ops_full) begin
                  err_in = ERR_OVERFLOW;
                  state_in = S_IDLE;
               end else begin
                  ctl.cmd    = CMD_PUSHO;
                  ctl.opcode = tok_ff;
                  state_in   = S_IDLE;
               end
            end
         end
         S_LOAD: begin
            if (stat.vals_lt2) begin
               err_in = ERR_MALFORMED;
               state_in = (tok_ff == TOK_END) ? S_FIN : S_IDLE;
            end else begin
               ctl.cmd = CMD_LOADV;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cur_ff == TOK_DIVIDE && stat.divzero) begin
               err_in = ERR_DIVZERO;
               state_in = (tok_ff == TOK_END) ? S_FIN : S_IDLE;
            end else begin
               ctl.cmd = CMD_EXEC;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!stat.busy) state_in = S_SETL;
         end
         S_FIN: begin
            // this extra state lets the bottom entry read settle
            if (err_ff == ERR_NONE && !stat.vals_one) err_in = ERR_MALFORMED;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!ov_ff || !rsp_stall) begin
               res_in  = (err_ff == ERR_NONE) ? bottom_value : '0;
               sts_in  = err_ff;
               ov_in   = 1'b1;
               err_in  = ERR_NONE;
               ctl.cmd = CMD_CLEAR;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff   <= ERR_NONE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
         ov_ff    <= ov_in;
      end
      tok_ff <= tok_in;
      cur_ff <= cur_in;
      res_ff <= res_in;
      sts_ff <= sts_in;
   end

   assign rsp_valid        = ov_ff;
   assign rsp_result_value = res_ff;
   assign rsp_status       = sts_ff;
endmodule

// ----- rtl/core/infix_expression_evaluator.sv -----
// Top level of the shunting-yard infix expression evaluator.
//
// Usage: feed one token per request on the req_ channel (req_op kind,
// req_digit_value for digits, req_bad_char to skip a character). A
// request is taken when req_valid is high and req_stall is low.
// Operators wait on an operator stack; each one is evaluated on the value
// stack as it leaves, with 32-bit wrapping arithmetic and truncating
// division. An end token drains the stacks and returns one response on
// the rsp_ channel: the value and a status (ok, divide by zero,
// malformed, overflow). Other tokens return nothing.
// Timing: a digit or ignored token is handled in the cycle it is taken.
// A token that looks at the operator stack passes S_SETL and S_LOOK and,
// per operator evaluated, S_LOAD, S_EXEC and S_WAIT; * and / use a
// shift-add multiply and restoring divide resolving one bit per cycle.
// End then passes S_FIN and S_OUT; the response is valid next cycle.
// Reset: stacks empty, no error, no response pending.
// Stall: the response holds in its register while rsp_stall is high;
// the block takes no new request until that response is gone.
module infix_expression_evaluator #(
   parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_digit_value,
   input  logic        req_bad_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]  rsp_status
);
   import iee_pkg::*;

   ctl_type           ctl;
   stat_type          stat;
   logic [3:0]        digit;
   logic [DATA_W-1:0] bottom_value;
   logic [DATA_W-1:0] result;

   // sequence the tokens
   iee_control u_control (
      .clock, .reset,
      .req_valid, .req_stall, .req_op, .req_digit_value, .req_bad_char,
      .stat, .ctl, .digit, .bottom_value,
      .rsp_valid, .rsp_stall,
      .rsp_result_value(result), .rsp_status
   );

   // hold the stacks and do the arithmetic
   iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
      .clock, .reset, .ctl, .digit, .stat, .bottom_value
   );

   assign rsp_result_value = $signed(result);
endmodule
